// ===== hw/rtl/kse_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and scancode tables for the keyboard scancode line editor.
// No dependencies; imported by every module of the block.
package kse_pkg;

  localparam int LEN_W         = 8;
  localparam int LINE_CAPACITY = 254;
  localparam int TABLE_SIZE    = 58;
  localparam int QUEUE_DEPTH   = 2;   // power of two
  localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  // Result actions
  localparam logic [3:0] ACT_NONE        = 4'd0;
  localparam logic [3:0] ACT_APPEND      = 4'd1;
  localparam logic [3:0] ACT_ERASE       = 4'd2;
  localparam logic [3:0] ACT_ENTER       = 4'd3;
  localparam logic [3:0] ACT_SCROLL_UP   = 4'd4;
  localparam logic [3:0] ACT_SCROLL_DOWN = 4'd5;
  localparam logic [3:0] ACT_HIST_UP     = 4'd6;
  localparam logic [3:0] ACT_HIST_DOWN   = 4'd7;
  localparam logic [3:0] ACT_TAB         = 4'd8;

  // Set-1 scancodes
  localparam logic [7:0] SC_CTRL   = 8'h1D;
  localparam logic [7:0] SC_LSHIFT = 8'h2A;
  localparam logic [7:0] SC_RSHIFT = 8'h36;
  localparam logic [7:0] SC_C      = 8'h2E;
  localparam logic [7:0] SC_UP     = 8'h48;
  localparam logic [7:0] SC_DOWN   = 8'h50;

  // Control characters in the tables
  localparam logic [6:0] ASCII_NUL = 7'h00;
  localparam logic [6:0] ASCII_BS  = 7'h08;
  localparam logic [6:0] ASCII_TAB = 7'h09;
  localparam logic [6:0] ASCII_LF  = 7'h0A;

  // Command kinds passed from the classifier to the line executor
  localparam logic [1:0] CMD_PASS   = 2'd0;
  localparam logic [1:0] CMD_CLEAR  = 2'd1;
  localparam logic [1:0] CMD_APPEND = 2'd2;
  localparam logic [1:0] CMD_ERASE  = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] action;     // used by CMD_PASS
    logic [6:0] chr;        // used by CMD_APPEND
    logic       execute;
    logic       interrupt;
  } cmd_t;

  localparam logic [6:0] PLAIN_MAP [0:TABLE_SIZE-1] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
    7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
    7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
  };

  localparam logic [6:0] UPPER_MAP [0:TABLE_SIZE-1] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
    7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
    7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
    7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
    7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
  };

  // Holes and codes past the table give NUL
  function automatic logic [6:0] map_char(input logic shift, input logic [5:0] idx);
    logic [6:0] c;
    c = ASCII_NUL;
    if (idx < 6'(TABLE_SIZE)) begin
      c = shift ? UPPER_MAP[idx] : PLAIN_MAP[idx];
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/kse_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the line editor input and result words.
// No dependencies.
interface kse_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] scancode;

  modport source (output valid, output op, output scancode, input ready);
  modport sink   (input valid, input op, input scancode, output ready);
endinterface

interface kse_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] action;
  logic [6:0] char_code;
  logic [7:0] position;
  logic       execute;
  logic       interrupt;

  modport source (output valid, output action, output char_code, output position,
                  output execute, output interrupt, input ready);
  modport sink   (input valid, input action, input char_code, input position,
                  input execute, input interrupt, output ready);
endinterface

// ===== hw/rtl/kse_classify.sv =====
`timescale 1ns / 1ps
// Front end: accepts scancode words, tracks Shift/Ctrl and the GUI mode register,
// and turns each word into a command for the queue. Depends on kse_pkg, kse_if.
module kse_classify (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_write,
  input  logic            cfg_data,
  kse_in_if.sink          in_ch,
  output logic            push_valid,
  input  logic            push_ready,
  output kse_pkg::cmd_t   push_data
);
  import kse_pkg::*;

  logic       gui_mode;
  logic       shift_held;
  logic       ctrl_held;
  logic       shift_held_next;
  logic       ctrl_held_next;
  logic [6:0] char_sel;
  logic [7:0] code;
  cmd_t       cmd;

  assign code     = in_ch.scancode;
  assign char_sel = map_char(shift_held, code[5:0]);

  always_comb begin
    cmd             = '0;
    cmd.kind        = CMD_PASS;
    cmd.action      = ACT_NONE;
    shift_held_next = shift_held;
    ctrl_held_next  = ctrl_held;
    if (in_ch.op) begin
      cmd.kind = CMD_CLEAR;
    end else if (code[7]) begin
      // release: drop the modifier, no action
      if (code[6:0] == SC_CTRL[6:0]) ctrl_held_next = 1'b0;
      if (code[6:0] == SC_LSHIFT[6:0] || code[6:0] == SC_RSHIFT[6:0]) begin
        shift_held_next = 1'b0;
      end
    end else if (code == SC_CTRL) begin
      ctrl_held_next = 1'b1;
    end else if (code inside {SC_LSHIFT, SC_RSHIFT}) begin
      shift_held_next = 1'b1;
    end else begin
      if (ctrl_held && code == SC_C) begin
        cmd.interrupt = 1'b1;
        cmd.execute   = 1'b1;
      end
      if (code == SC_UP) begin
        cmd.action = gui_mode ? ACT_SCROLL_UP : ACT_HIST_UP;
      end else if (code == SC_DOWN) begin
        cmd.action = gui_mode ? ACT_SCROLL_DOWN : ACT_HIST_DOWN;
      end else if (code < 8'(TABLE_SIZE)) begin
        case (char_sel)
          ASCII_LF: begin
            cmd.action  = ACT_ENTER;
            cmd.execute = 1'b1;
          end
          ASCII_BS:  cmd.kind = CMD_ERASE;
          ASCII_TAB: cmd.action = ACT_TAB;
          ASCII_NUL: cmd.action = ACT_NONE;
          default: begin
            cmd.kind = CMD_APPEND;
            cmd.chr  = char_sel;
          end
        endcase
      end
    end
  end

  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid;
  assign push_data   = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      gui_mode   <= 1'b0;
      shift_held <= 1'b0;
      ctrl_held  <= 1'b0;
    end else begin
      if (cfg_write) gui_mode <= cfg_data;
      if (in_ch.valid && in_ch.ready) begin
        shift_held <= shift_held_next;
        ctrl_held  <= ctrl_held_next;
      end
    end
  end

endmodule

// ===== hw/rtl/kse_cmd_queue.sv =====
`timescale 1ns / 1ps
// Small FIFO of classified commands between the front end and the executor.
// Depends on kse_pkg.
module kse_cmd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  kse_pkg::cmd_t   push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output kse_pkg::cmd_t   pop_data
);
  import kse_pkg::*;

  cmd_t                entries [0:QUEUE_DEPTH-1];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_CW-1:0] count;
  logic                push;
  logic                pop;

  assign push_ready = (count != QUEUE_CW'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QUEUE_AW'(1);
      if (pop)  rd_ptr <= rd_ptr + QUEUE_AW'(1);
      if (push && !pop)      count <= count + QUEUE_CW'(1);
      else if (pop && !push) count <= count - QUEUE_CW'(1);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QUEUE_CW'(QUEUE_DEPTH))
    else $error("command queue count past depth");

endmodule

// ===== hw/rtl/kse_exec.sv =====
`timescale 1ns / 1ps
// Back end: applies queued commands to the line length and registers the result word.
// Depends on kse_pkg, kse_if.
module kse_exec (
  input  logic            clk,
  input  logic            rst,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  kse_pkg::cmd_t   pop_data,
  kse_out_if.source       out_ch
);
  import kse_pkg::*;

  logic [LEN_W-1:0] line_length;
  logic [LEN_W-1:0] line_length_next;
  logic             out_valid;
  logic [3:0]       action;
  logic [6:0]       char_code;
  logic [LEN_W-1:0] position;
  logic             execute;
  logic             interrupt;
  logic [3:0]       action_next;
  logic [6:0]       char_code_next;
  logic [LEN_W-1:0] position_next;
  logic             execute_next;
  logic             interrupt_next;
  logic             pop;

  // Advance whenever the result register is empty or being drained
  assign pop_ready = !out_valid || out_ch.ready;
  assign pop       = pop_valid && pop_ready;

  always_comb begin
    line_length_next = line_length;
    action_next      = ACT_NONE;
    char_code_next   = ASCII_NUL;
    position_next    = '0;
    execute_next     = 1'b0;
    interrupt_next   = 1'b0;
    case (pop_data.kind)
      CMD_CLEAR: line_length_next = '0;
      CMD_ERASE: begin
        if (line_length != '0) begin
          line_length_next = line_length - LEN_W'(1);
          action_next      = ACT_ERASE;
          char_code_next   = ASCII_BS;
          position_next    = line_length - LEN_W'(1);
        end
      end
      CMD_APPEND: begin
        execute_next   = pop_data.execute;
        interrupt_next = pop_data.interrupt;
        // drop the character silently when the line is full
        if (int'(line_length) < LINE_CAPACITY && line_length != LEN_MAX) begin
          line_length_next = line_length + LEN_W'(1);
          action_next      = ACT_APPEND;
          char_code_next   = pop_data.chr;
          position_next    = line_length;
        end
      end
      default: begin
        action_next    = pop_data.action;
        execute_next   = pop_data.execute;
        interrupt_next = pop_data.interrupt;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (pop) begin
        line_length <= line_length_next;
        out_valid   <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      action    <= action_next;
      char_code <= char_code_next;
      position  <= position_next;
      execute   <= execute_next;
      interrupt <= interrupt_next;
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.action    = action;
  assign out_ch.char_code = char_code;
  assign out_ch.position  = position;
  assign out_ch.execute   = execute;
  assign out_ch.interrupt = interrupt;

  a_erase_tracks_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && action == ACT_ERASE |-> char_code == ASCII_BS && position == line_length)
    else $error("erase word does not match line length");

  a_append_tracks_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && action == ACT_APPEND |-> line_length == position + LEN_W'(1))
    else $error("append word does not match line length");

  a_intr_executes: assert property (@(posedge clk) disable iff (rst)
    out_valid && interrupt |-> execute)
    else $error("interrupt without execute");

endmodule

// ===== hw/rtl/keyboard_scancode_line_editor.sv =====
`timescale 1ns / 1ps
// Keyboard scancode line editor, top level. Depends on kse_pkg, kse_if,
// kse_classify, kse_cmd_queue and kse_exec.
//
// Input channel in_ch carries one word per key event: op = 0 delivers a raw set-1
// scancode byte, op = 1 clears the line length after the line is consumed.
// Output channel out_ch returns exactly one result word per input word: the
// editing action, the character, the line position and the execute/interrupt
// pulses. Both channels move a word at a clock edge with valid and ready high.
// cfg_write/cfg_data load the GUI mode bit (arrows scroll when set, recall history
// when clear); write it only while the block is idle.
// Throughput: one word per cycle while out_ch is not stalled. The classifier takes a
// word into a two-entry command queue in the cycle it arrives; the executor updates
// the line length and loads the result register from the queue head. An accepted
// word is registered in the queue, then in the result register that drives out_ch.
// When the receiver stalls, the result register holds and the queue absorbs up to
// two more words before in_ch.ready drops; no word is lost or repeated.
// Reset clears the GUI mode, the Shift/Ctrl flags, the line length and the queue.
module keyboard_scancode_line_editor (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_write,
  input  logic      cfg_data,
  kse_in_if.sink    in_ch,
  kse_out_if.source out_ch
);
  import kse_pkg::*;

  logic push_valid;
  logic push_ready;
  cmd_t push_data;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_data;

  kse_classify u_classify (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  kse_cmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  kse_exec u_exec (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

endmodule

// ===== bench/kse_line_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the keyboard scancode line editor: predicts one result word per
// input word and compares it with out_ch. Depends on kse_pkg and kse_if.
module kse_line_checker (
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic cfg_data,
  kse_in_if    in_ch,
  kse_out_if   out_ch,
  output int   err_count,
  output int   outstanding
);
  import kse_pkg::*;

  typedef struct packed {
    logic [3:0] action;
    logic [6:0] char_code;
    logic [7:0] position;
    logic       execute;
    logic       interrupt;
  } edit_result_t;

  localparam logic [6:0] LOWER_KEYS [0:TABLE_SIZE-1] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
    7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
    7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
  };

  localparam logic [6:0] SHIFTED_KEYS [0:TABLE_SIZE-1] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
    7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
    7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
    7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
    7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
  };

  edit_result_t expected_q [$];
  logic         arrows_scroll;
  logic         shift_down;
  logic         ctrl_down;
  logic [7:0]   line_len;
  int           reported;

  function automatic edit_result_t edit_line(input logic op, input logic [7:0] code);
    edit_result_t r;
    logic [6:0]   ch;
    r = '0;
    if (op) begin
      line_len = '0;
    end else if (code[7]) begin
      // break code: only the modifier flags care
      if (code[6:0] == SC_CTRL[6:0]) ctrl_down = 1'b0;
      if (code[6:0] == SC_LSHIFT[6:0] || code[6:0] == SC_RSHIFT[6:0]) shift_down = 1'b0;
    end else if (code == SC_CTRL) begin
      ctrl_down = 1'b1;
    end else if (code == SC_LSHIFT || code == SC_RSHIFT) begin
      shift_down = 1'b1;
    end else begin
      if (ctrl_down && code == SC_C) begin
        r.interrupt = 1'b1;
        r.execute   = 1'b1;
      end
      if (code == SC_UP) begin
        r.action = arrows_scroll ? ACT_SCROLL_UP : ACT_HIST_UP;
      end else if (code == SC_DOWN) begin
        r.action = arrows_scroll ? ACT_SCROLL_DOWN : ACT_HIST_DOWN;
      end else if (code < TABLE_SIZE) begin
        ch = shift_down ? SHIFTED_KEYS[code[5:0]] : LOWER_KEYS[code[5:0]];
        if (ch == ASCII_LF) begin
          r.action  = ACT_ENTER;
          r.execute = 1'b1;
        end else if (ch == ASCII_BS) begin
          if (line_len != 0) begin
            line_len    = line_len - 8'd1;
            r.action    = ACT_ERASE;
            r.char_code = ASCII_BS;
            r.position  = line_len;
          end
        end else if (ch == ASCII_TAB) begin
          r.action = ACT_TAB;
        end else if (ch != ASCII_NUL) begin
          // drop the character once the line is full
          if (line_len < LINE_CAPACITY && line_len != 8'hFF) begin
            r.action    = ACT_APPEND;
            r.char_code = ch;
            r.position  = line_len;
            line_len    = line_len + 8'd1;
          end
        end
      end
    end
    return r;
  endfunction

  task automatic flag_error(input string what, input edit_result_t want,
                            input edit_result_t got);
    if (reported < 10) begin
      $display("%0t: %s: expected act=%0d chr=%h pos=%0d exe=%b int=%b, got act=%0d chr=%h pos=%0d exe=%b int=%b",
               $realtime, what, want.action, want.char_code, want.position,
               want.execute, want.interrupt, got.action, got.char_code,
               got.position, got.execute, got.interrupt);
    end
    reported++;
    err_count++;
  endtask

  always @(posedge clk) begin
    edit_result_t want;
    edit_result_t got;
    if (rst) begin
      arrows_scroll = 1'b0;
      shift_down    = 1'b0;
      ctrl_down     = 1'b0;
      line_len      = '0;
      reported      = 0;
      err_count     = 0;
      expected_q.delete();
    end else begin
      if (cfg_write) arrows_scroll = cfg_data;
      // retire the oldest expectation before queueing the new word
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.action, out_ch.char_code, out_ch.position,
                out_ch.execute, out_ch.interrupt};
        if (expected_q.size() == 0) begin
          flag_error("unexpected result word", '0, got);
        end else begin
          want = expected_q.pop_front();
          if (got.action !== want.action || got.char_code !== want.char_code ||
              got.position !== want.position || got.execute !== want.execute ||
              got.interrupt !== want.interrupt) begin
            flag_error("result mismatch", want, got);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_q.push_back(edit_line(in_ch.op, in_ch.scancode));
      end
    end
    outstanding <= expected_q.size();
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the keyboard scancode line editor: clock, reset, stimulus,
// watchdog and verdict. Depends on kse_pkg, kse_if, the block and kse_line_checker.
module tb_top;
  import kse_pkg::*;

  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 6;
  localparam int PHASE_WORDS  = 650;

  localparam logic [7:0] SC_ESC   = 8'h01;
  localparam logic [7:0] SC_BKSP  = 8'h0E;
  localparam logic [7:0] SC_TAB   = 8'h0F;
  localparam logic [7:0] SC_Q     = 8'h10;
  localparam logic [7:0] SC_P     = 8'h19;
  localparam logic [7:0] SC_ENTER = 8'h1C;
  localparam logic [7:0] SC_A     = 8'h1E;
  localparam logic [7:0] SC_L     = 8'h26;
  localparam logic [7:0] SC_Z     = 8'h2C;
  localparam logic [7:0] SC_M     = 8'h32;
  localparam logic [7:0] SC_SPACE = 8'h39;
  localparam logic [7:0] SC_HOLE  = 8'h38;
  localparam logic [7:0] SC_PAST  = 8'h3A;
  localparam logic [7:0] SC_E0    = 8'hE0;
  localparam logic [7:0] BREAK    = 8'h80;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic cfg_data;
  int   err_count;
  int   outstanding;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   quiet_cycles;
  int   words_sent;

  kse_in_if  in_ch ();
  kse_out_if out_ch ();

  keyboard_scancode_line_editor u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  kse_line_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .err_count   (err_count),
    .outstanding (outstanding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ch.ready = ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Call at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(input logic op, input logic [7:0] code);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid    = 1'b1;
    in_ch.op       = op;
    in_ch.scancode = code;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic set_gui_mode(input logic mode);
    in_ch.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_write = 1'b1;
    cfg_data  = mode;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  function automatic logic [7:0] letter_key();
    case ($urandom_range(0, 2))
      0:       return 8'($urandom_range(SC_Q, SC_P));
      1:       return 8'($urandom_range(SC_A, SC_L));
      default: return 8'($urandom_range(SC_Z, SC_M));
    endcase
  endfunction

  function automatic logic [7:0] typing_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 8'($urandom_range(SC_ESC, SC_SPACE));
    if (r < 59) return $urandom_range(0, 1) ? SC_LSHIFT : SC_RSHIFT;
    if (r < 63) return ($urandom_range(0, 1) ? SC_LSHIFT : SC_RSHIFT) | BREAK;
    if (r < 66) return SC_CTRL;
    if (r < 69) return SC_CTRL | BREAK;
    if (r < 73) return SC_C;
    if (r < 78) return SC_BKSP;
    if (r < 82) return $urandom_range(0, 1) ? SC_UP : SC_DOWN;
    if (r < 88) return 8'($urandom_range(8'h80, 8'hFF));
    if (r < 94) return 8'($urandom_range(8'h00, 8'h7F));
    return 8'($urandom);
  endfunction

  // Lines of typing with edits, submitted and usually consumed; the first
  // line of each phase runs past capacity.
  task automatic type_lines(input int words);
    int   stop_at;
    int   len;
    int   k;
    logic heavy;
    stop_at = words_sent + words;
    heavy   = 1'b1;
    while (words_sent < stop_at) begin
      len = heavy ? $urandom_range(256, 280) : $urandom_range(0, 30);
      for (k = 0; k < len; k++) begin
        send_word(1'b0, heavy ? letter_key() : typing_key());
      end
      if (heavy) send_word(1'b0, SC_BKSP);
      send_word(1'b0, SC_ENTER);
      if ($urandom_range(0, 3) != 0) send_word(1'b1, 8'($urandom));
      heavy = ($urandom_range(0, 39) == 0);
    end
  endtask

  initial begin
    rst            = 1'b1;
    cfg_write      = 1'b0;
    cfg_data       = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.op       = 1'b0;
    in_ch.scancode = '0;
    out_ch.ready   = 1'b0;
    words_sent     = 0;
    send_idle_pct  = 24;
    recv_idle_pct  = 54;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // directed: edits and modifiers, history arrows, more edits and odd codes, then scroll arrows
    send_word(1'b1, 8'hFF);
    send_word(1'b0, SC_BKSP);
    send_word(1'b0, SC_A);
    send_word(1'b0, SC_LSHIFT);
    send_word(1'b0, SC_Q);
    send_word(1'b0, SC_LSHIFT | BREAK);
    send_word(1'b0, SC_CTRL);
    send_word(1'b0, SC_C);
    send_word(1'b0, SC_RSHIFT);
    send_word(1'b0, SC_C);
    send_word(1'b0, SC_RSHIFT | BREAK);
    send_word(1'b0, SC_CTRL | BREAK);
    send_word(1'b0, SC_UP);
    send_word(1'b0, SC_DOWN);
    send_word(1'b0, SC_TAB);
    send_word(1'b0, SC_BKSP);
    send_word(1'b0, SC_ENTER);
    send_word(1'b0, 8'h00);
    send_word(1'b0, SC_HOLE);
    send_word(1'b0, SC_PAST);
    send_word(1'b0, 8'h7F);
    send_word(1'b0, SC_E0);
    send_word(1'b0, BREAK);
    set_gui_mode(1'b1);
    send_word(1'b0, SC_UP);
    send_word(1'b0, SC_DOWN);

    type_lines(PHASE_WORDS);
    send_idle_pct = 54;
    recv_idle_pct = 24;
    set_gui_mode(1'b0);
    type_lines(PHASE_WORDS);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_gui_mode(1'($urandom_range(0, 1)));
    type_lines(PHASE_WORDS);

    in_ch.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/kse_pkg.sv
hw/rtl/kse_if.sv
hw/rtl/kse_classify.sv
hw/rtl/kse_cmd_queue.sv
hw/rtl/kse_exec.sv
hw/rtl/keyboard_scancode_line_editor.sv
bench/kse_line_checker.sv
bench/tb_top.sv
